>>> hdl/iirdf_pkg.sv
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared opcodes, field widths and the controller command bundle of the
// direct form I IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf_pkg;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned COEF_W   = 32;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned OUT_W    = 24;
   localparam int unsigned OPER_W   = 24;
   localparam int unsigned PROD_W   = COEF_W + OPER_W;
   localparam int unsigned ACC_W    = 64;

   localparam logic [OPCODE_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WR_FWD = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_WR_FB  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic shift_in;
      logic clr_acc;
      logic wr_fwd;
      logic wr_fb;
      logic clr_hist;
      logic mul_en;
      logic rnd_en;
      logic fin;
   } iirdf_cmd_type;

endpackage

`default_nettype wire

>>> hdl/iirdf_ctrl.sv
// ----------------------------------------------------------------------------
// iirdf_ctrl
// Sequencer of the filter: decodes requests, steps the tap counter over the
// shared multiplier, orders rounding and holds the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf_ctrl #(
   parameter int unsigned ORDER = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [iirdf_pkg::OPCODE_W-1:0]      req_opcode,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output iirdf_pkg::iirdf_cmd_type            cmd,
   output logic [$clog2(4*ORDER+1)-1:0]        tap
);

   localparam int unsigned NTAP  = 4 * ORDER + 1;
   localparam int unsigned TAP_W = $clog2(NTAP);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_RND   = 3'd3;
   localparam logic [2:0] S_SAT   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             valid_ff, valid_in;

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  iirdf_pkg::OP_FILTER: begin
                     cmd.shift_in = 1'b1;
                     cmd.clr_acc  = 1'b1;
                     tap_in       = '0;
                     state_in     = S_MAC;
                  end
                  iirdf_pkg::OP_WR_FWD: cmd.wr_fwd   = 1'b1;
                  iirdf_pkg::OP_WR_FB:  cmd.wr_fb    = 1'b1;
                  iirdf_pkg::OP_CLEAR:  cmd.clr_hist = 1'b1;
                  default: ;
               endcase
            end
         end
         S_MAC: begin
            cmd.mul_en = 1'b1;
            if (tap_ff == TAP_W'(NTAP - 1)) begin
               state_in = S_DRAIN;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         S_DRAIN: state_in = S_RND;
         S_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = S_SAT;
         end
         S_SAT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.fin) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tap_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign tap       = tap_ff;

endmodule

`default_nettype wire

>>> hdl/iirdf_datapath.sv
// ----------------------------------------------------------------------------
// iirdf_datapath
// Coefficient and history registers, shared 32x24 multiplier, 64-bit
// accumulator, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf_datapath #(
   parameter int unsigned ORDER = 4
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  iirdf_pkg::iirdf_cmd_type                cmd,
   input  wire  [$clog2(4*ORDER+1)-1:0]            tap,
   input  wire  [iirdf_pkg::INDEX_W-1:0]           coef_index,
   input  wire  signed [iirdf_pkg::COEF_W-1:0]     coef_value,
   input  wire  signed [iirdf_pkg::SAMPLE_W-1:0]   sample,
   output logic signed [iirdf_pkg::OUT_W-1:0]      filtered,
   output logic                                    saturated
);

   localparam int unsigned NFWD  = 2 * ORDER + 1;
   localparam int unsigned NFB   = 2 * ORDER;
   localparam int unsigned NTAP  = NFWD + NFB;
   localparam int unsigned TAP_W = $clog2(NTAP);
   localparam int unsigned FWD_W = $clog2(NFWD);
   localparam int unsigned FB_W  = $clog2(NFB);

   localparam int unsigned COEF_W = iirdf_pkg::COEF_W;
   localparam int unsigned OPER_W = iirdf_pkg::OPER_W;
   localparam int unsigned PROD_W = iirdf_pkg::PROD_W;
   localparam int unsigned ACC_W  = iirdf_pkg::ACC_W;
   localparam int unsigned OUT_W  = iirdf_pkg::OUT_W;
   localparam int unsigned Q_W    = ACC_W - 24;

   logic signed [iirdf_pkg::SAMPLE_W-1:0] xh_ff [NFWD];
   logic signed [OUT_W-1:0]               yh_ff [NFB];
   logic signed [COEF_W-1:0]              fwd_ff [NFWD];
   logic signed [COEF_W-1:0]              fb_ff [NFB];

   logic [TAP_W-1:0]          fb_idx;
   logic signed [COEF_W-1:0]  coef_sel;
   logic signed [OPER_W-1:0]  oper_sel;
   logic                      sub_sel;
   logic signed [PROD_W-1:0]  mult;

   logic signed [PROD_W-1:0]  prod_ff;
   logic                      prod_sub_ff;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]          mag;
   logic [ACC_W-1:0]          sum_ff;
   logic                      neg_ff;
   logic [Q_W-1:0]            q;
   logic signed [Q_W:0]       qs;
   logic signed [OUT_W-1:0]   y;
   logic                      sat;

   // select the operand pair of the current tap
   always_comb begin
      fb_idx   = TAP_W'(32'(tap) - NFWD);
      coef_sel = '0;
      oper_sel = '0;
      sub_sel  = 1'b0;
      if (32'(tap) < NFWD) begin
         coef_sel = fwd_ff[tap[FWD_W-1:0]];
         oper_sel = {xh_ff[tap[FWD_W-1:0]], 8'b0};
      end else begin
         coef_sel = fb_ff[fb_idx[FB_W-1:0]];
         oper_sel = yh_ff[fb_idx[FB_W-1:0]];
         sub_sel  = 1'b1;
      end
   end

   assign mult = coef_sel * oper_sel;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr_acc) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         if (prod_sub_ff) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign q   = sum_ff[ACC_W-1:24];
   assign qs  = neg_ff ? -{1'b0, q} : {1'b0, q};

   always_comb begin
      y   = qs[OUT_W-1:0];
      sat = 1'b0;
      if (qs > (Q_W+1)'(8388607)) begin
         y   = OUT_W'(8388607);
         sat = 1'b1;
      end else if (qs < -(Q_W+1)'(8388608)) begin
         y   = {1'b1, {(OUT_W-1){1'b0}}};
         sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff     <= mult;
         prod_sub_ff <= sub_sel;
      end
      acc_ff <= acc_in;
      if (cmd.rnd_en) begin
         sum_ff <= mag + ACC_W'(64'h800000);
         neg_ff <= acc_ff[ACC_W-1];
      end
      if (cmd.fin) begin
         filtered  <= y;
         saturated <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_hist) begin
         for (int i = 0; i < NFWD; i++) xh_ff[i] <= '0;
      end else if (cmd.shift_in) begin
         xh_ff[0] <= sample;
         for (int i = 1; i < NFWD; i++) xh_ff[i] <= xh_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_hist) begin
         for (int i = 0; i < NFB; i++) yh_ff[i] <= '0;
      end else if (cmd.fin) begin
         yh_ff[0] <= y;
         for (int i = 1; i < NFB; i++) yh_ff[i] <= yh_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NFWD; i++) fwd_ff[i] <= '0;
         for (int i = 0; i < NFB; i++) fb_ff[i] <= '0;
      end else begin
         for (int i = 0; i < NFWD; i++) begin
            if (cmd.wr_fwd && 32'(coef_index) == i) fwd_ff[i] <= coef_value;
         end
         for (int i = 0; i < NFB; i++) begin
            if (cmd.wr_fb && 32'(coef_index) == i + 1) fb_ff[i] <= coef_value;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/iir_direct_form_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_filter
// Direct form I IIR filter with 2*ORDER+1 forward and 2*ORDER feedback taps,
// Q8.24 coefficients, 64-bit accumulation and a rounded, saturated Q16.8
// output.
//
//   channel  dir  tdata                                    tuser
//   req_     in   [3:0] coef_index [35:4] coef_value       [1:0] opcode
//                 [51:36] sample (55:52 zero)
//   rsp_     out  [23:0] filtered                          [0] saturated
//
// A filter request steps the single shared multiplier over all taps, then
// drains, rounds and saturates before its result is offered; coefficient
// writes and history clears are applied when they are accepted.
// Reset clears histories, coefficients and control state at once.
// A result waiting on rsp_tready does not block acceptance of the next
// request; a following result holds until the previous one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_filter #(
   parameter int unsigned ORDER = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // coef_index, coef_value, sample
   input  wire  [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // filtered
   output logic        rsp_tuser    // saturated
);

   localparam int unsigned TAP_W = $clog2(4 * ORDER + 1);

   iirdf_pkg::iirdf_cmd_type cmd;
   logic [TAP_W-1:0]         tap;
   logic signed [iirdf_pkg::OUT_W-1:0] filtered;

   iirdf_ctrl #(
      .ORDER (ORDER)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .cmd        (cmd),
      .tap        (tap)
   );

   iirdf_datapath #(
      .ORDER (ORDER)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .tap        (tap),
      .coef_index (req_tdata[3:0]),
      .coef_value (req_tdata[35:4]),
      .sample     (req_tdata[51:36]),
      .filtered   (filtered),
      .saturated  (rsp_tuser)
   );

   assign rsp_tdata = filtered;

endmodule

`default_nettype wire
